>>> sv/pfr_pkg.sv
// Shared types, constants and helpers of the page frame replacement core.
`default_nettype none

package pfr_pkg;

    localparam int STAMP_W    = 32;
    localparam int CNT_W      = 16;
    localparam int POL_W      = 2;
    localparam int FRM_W      = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;
    localparam int TOTAL_W    = 32;

    localparam logic [CFG_IDX_W-1:0] REG_POLICY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAMES = 2'd1;

    localparam logic [POL_W-1:0]   POLICY_RESET = 2'd0;
    localparam logic [FRM_W-1:0]   FRAMES_RESET = 5'd4;
    localparam logic [STAMP_W-1:0] STAMP_MAX    = 32'hFFFF_FFFF;
    localparam logic [CNT_W-1:0]   CNT_MAX      = 16'hFFFF;
    localparam logic [CNT_W-1:0]   CNT_ONE      = 16'd1;

    typedef enum logic [1:0] {
        POL_FIFO = 2'd0,
        POL_LRU  = 2'd1,
        POL_LFU  = 2'd2
    } t_policy;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE
    } t_state;

    // Per-frame usage record: last-use stamp and use count.
    typedef struct packed {
        logic [STAMP_W-1:0] stamp;
        logic [CNT_W-1:0]   count;
    } t_usage;

    function automatic logic [CNT_W-1:0] count_up(input logic [CNT_W-1:0] c);
        count_up = (c != CNT_MAX) ? c + CNT_ONE : CNT_MAX;
    endfunction

endpackage

`default_nettype wire

>>> sv/page_frame_replacement_core.sv
// Top level of the page frame replacement core: sequencer, counters, config and result register.
`default_nettype none

// Page frame replacement core. Each input item is one page reference; each
// produces exactly one result item with hit, replaced, the evicted page (zero
// when nothing was evicted) and the saturating running miss total. Frame
// state (page, last-use stamp, use count) lives in a single-port-read frame
// table; an item reads every frame in use once, one frame per cycle, then
// writes back the one frame it touched. Frames read are frames_in_use clamped
// to 1..MAX_FRAMES; write-back waits until the result register is free. The
// input stalls while an item is in flight; a finished result waits in the
// output register while the next item is accepted and scanned.
// Policy: 0 FIFO (round-robin pointer), 1 LRU (smallest stamp), 2 LFU
// (smallest count, ties to smallest stamp); code 3 acts as FIFO. Config
// registers: index 0 policy, index 1 frames_in_use; write them only while the
// core is idle. Stamps and counts read as zero until a frame is first
// written, so no clearing pass follows reset.
module page_frame_replacement_core #(
    parameter int MAX_FRAMES = 16,
    parameter int PAGE_BITS  = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // reference input
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic [PAGE_BITS-1:0]              i_page_number,
    // result output
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic                                   o_hit,
    output logic                                   o_replaced,
    output logic      [PAGE_BITS-1:0]              o_victim_page,
    output logic      [pfr_pkg::TOTAL_W-1:0]       o_fault_total,
    // config write
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [pfr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [pfr_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int AW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CW = $clog2(MAX_FRAMES + 1);
    localparam int XW = (CW > pfr_pkg::FRM_W) ? CW : pfr_pkg::FRM_W;

    // Config registers
    logic [pfr_pkg::POL_W-1:0] r_policy;
    logic [pfr_pkg::FRM_W-1:0] r_frames;

    // Persistent state
    logic [CW-1:0]                 r_filled;
    logic [AW-1:0]                 r_ptr;
    logic [pfr_pkg::STAMP_W-1:0]   r_tick;
    logic [pfr_pkg::TOTAL_W-1:0]   r_miss;

    // Per-item context
    pfr_pkg::t_state       r_state, n_state;
    logic [PAGE_BITS-1:0]  r_key;
    logic [CW-1:0]         r_n;
    logic [CW-1:0]         r_used;
    logic [AW-1:0]         r_slot;
    pfr_pkg::t_policy      r_pol;
    logic [CW-1:0]         r_rd_idx;
    logic                  r_cmp_vld;
    logic [AW-1:0]         r_cmp_idx;

    // Result register
    logic                          r_out_valid;
    logic                          r_hit;
    logic                          r_replaced;
    logic [PAGE_BITS-1:0]          r_victim;
    logic [pfr_pkg::TOTAL_W-1:0]   r_fault;

    // Sequencer controls
    logic in_acc;
    logic rd_en;
    logic wr_en;
    logic out_free;

    // Accept-time decode
    logic [XW-1:0]     frames_x;
    logic [CW-1:0]     n_clamp;
    logic [CW-1:0]     used_now;
    logic [AW-1:0]     slot_now;
    pfr_pkg::t_policy  pol_now;

    // Memory and scan wiring
    logic [PAGE_BITS-1:0] rd_page;
    pfr_pkg::t_usage      rd_use;
    logic                 sc_hit;
    logic [AW-1:0]        sc_hit_idx;
    pfr_pkg::t_usage      sc_hit_use;
    logic [AW-1:0]        sc_best_idx;
    logic [PAGE_BITS-1:0] sc_best_page;
    pfr_pkg::t_usage      sc_best_use;
    logic [PAGE_BITS-1:0] sc_fifo_page;
    pfr_pkg::t_usage      sc_fifo_use;

    // Write-back decode
    logic                         miss;
    logic                         fill;
    logic                         repl;
    logic [AW-1:0]                wr_addr;
    pfr_pkg::t_usage              wr_use;
    logic [PAGE_BITS-1:0]         victim;
    logic [pfr_pkg::TOTAL_W-1:0]  miss_next;
    logic [CW:0]                  slot_inc;
    logic [AW-1:0]                ptr_next;

    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_valid || !i_out_stall;

    // Config writes; indexes beyond the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= pfr_pkg::POLICY_RESET;
            r_frames <= pfr_pkg::FRAMES_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == pfr_pkg::REG_POLICY) begin
                r_policy <= i_cfg_data[pfr_pkg::POL_W-1:0];
            end else if (i_cfg_index == pfr_pkg::REG_FRAMES) begin
                r_frames <= i_cfg_data;
            end
        end
    end

    // Clamp the frame count, pick the used span, wrap the FIFO pointer, map the policy code.
    always_comb begin
        frames_x = XW'(r_frames);
        if (frames_x == '0) begin
            n_clamp = CW'(1);
        end else if (frames_x > XW'(MAX_FRAMES)) begin
            n_clamp = CW'(MAX_FRAMES);
        end else begin
            n_clamp = frames_x[CW-1:0];
        end
        used_now = (r_filled < n_clamp) ? r_filled : n_clamp;
        slot_now = (CW'(r_ptr) >= n_clamp) ? '0 : r_ptr;
        unique case (r_policy)
            pfr_pkg::POL_LRU: pol_now = pfr_pkg::POL_LRU;
            pfr_pkg::POL_LFU: pol_now = pfr_pkg::POL_LFU;
            default:          pol_now = pfr_pkg::POL_FIFO;
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pfr_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and sequencer controls
    always_comb begin
        n_state    = r_state;
        in_acc     = 1'b0;
        rd_en      = 1'b0;
        wr_en      = 1'b0;
        o_in_stall = 1'b1;
        unique case (r_state)
            pfr_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                in_acc     = i_in_valid;
                if (i_in_valid) begin
                    n_state = pfr_pkg::ST_SCAN;
                end
            end
            pfr_pkg::ST_SCAN: begin
                rd_en = (r_rd_idx != r_n);
                // last frame consumed and no read in flight
                if (r_rd_idx == r_n && !r_cmp_vld) begin
                    n_state = pfr_pkg::ST_WRITE;
                end
            end
            pfr_pkg::ST_WRITE: begin
                // hold until the result register frees up
                wr_en = out_free;
                if (out_free) begin
                    n_state = pfr_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pfr_pkg::ST_IDLE;
            end
        endcase
    end

    // Latch item context at acceptance; issue reads one frame per cycle.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_key  <= i_page_number;
            r_n    <= n_clamp;
            r_used <= used_now;
            r_slot <= slot_now;
            r_pol  <= pol_now;
        end
        r_cmp_idx <= r_rd_idx[AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_idx  <= '0;
            r_cmp_vld <= 1'b0;
        end else begin
            r_cmp_vld <= rd_en;
            if (in_acc) begin
                r_rd_idx <= '0;
            end else if (rd_en) begin
                r_rd_idx <= r_rd_idx + CW'(1);
            end
        end
    end

    pfr_frame_ram #(
        .MAX_FRAMES (MAX_FRAMES),
        .PAGE_BITS  (PAGE_BITS),
        .AW         (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_rd_idx[AW-1:0]),
        .o_rd_page (rd_page),
        .o_rd_use  (rd_use),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_page (r_key),
        .i_wr_use  (wr_use)
    );

    pfr_scan #(
        .PAGE_BITS (PAGE_BITS),
        .AW        (AW),
        .CW        (CW)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (in_acc),
        .i_vld       (r_cmp_vld),
        .i_idx       (r_cmp_idx),
        .i_page      (rd_page),
        .i_use       (rd_use),
        .i_key       (r_key),
        .i_used      (r_used),
        .i_slot      (r_slot),
        .i_pol       (r_pol),
        .o_hit       (sc_hit),
        .o_hit_idx   (sc_hit_idx),
        .o_hit_use   (sc_hit_use),
        .o_best_idx  (sc_best_idx),
        .o_best_page (sc_best_page),
        .o_best_use  (sc_best_use),
        .o_fifo_page (sc_fifo_page),
        .o_fifo_use  (sc_fifo_use)
    );

    // Write-back: hit refreshes, miss fills the next empty frame or evicts.
    always_comb begin
        miss      = !sc_hit;
        fill      = miss && (r_used < r_n);
        repl      = miss && !fill;
        miss_next = (miss && r_miss != pfr_pkg::STAMP_MAX) ? r_miss + 32'd1 : r_miss;
        slot_inc  = (CW+1)'(r_slot) + (CW+1)'(1);
        ptr_next  = (slot_inc >= (CW+1)'(r_n)) ? '0 : slot_inc[AW-1:0];
        victim    = '0;
        priority if (sc_hit) begin
            wr_addr      = sc_hit_idx;
            wr_use.stamp = r_tick;
            wr_use.count = pfr_pkg::count_up(sc_hit_use.count);
        end else if (fill) begin
            wr_addr      = r_used[AW-1:0];
            wr_use.stamp = (r_pol != pfr_pkg::POL_FIFO) ? r_tick : '0;
            wr_use.count = (r_pol == pfr_pkg::POL_LFU) ? pfr_pkg::CNT_ONE : '0;
        end else begin
            unique case (r_pol)
                pfr_pkg::POL_LRU: begin
                    wr_addr      = sc_best_idx;
                    wr_use.stamp = r_tick;
                    wr_use.count = sc_best_use.count;
                    victim       = sc_best_page;
                end
                pfr_pkg::POL_LFU: begin
                    wr_addr      = sc_best_idx;
                    wr_use.stamp = r_tick;
                    wr_use.count = pfr_pkg::CNT_ONE;
                    victim       = sc_best_page;
                end
                default: begin
                    wr_addr = r_slot;
                    wr_use  = sc_fifo_use;
                    victim  = sc_fifo_page;
                end
            endcase
        end
    end

    // Persistent counters: tick advances per item, the rest on write-back.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filled <= '0;
            r_ptr    <= '0;
            r_tick   <= '0;
            r_miss   <= '0;
        end else begin
            if (in_acc && r_tick != pfr_pkg::STAMP_MAX) begin
                r_tick <= r_tick + 32'd1;
            end
            if (wr_en) begin
                r_miss <= miss_next;
                if (fill) begin
                    r_filled <= r_used + CW'(1);
                end
                if (repl && r_pol == pfr_pkg::POL_FIFO) begin
                    r_ptr <= ptr_next;
                end
            end
        end
    end

    // Result register: load on write-back, drop once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (wr_en) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_hit      <= sc_hit;
            r_replaced <= repl;
            r_victim   <= victim;
            r_fault    <= miss_next;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_hit         = r_hit;
    assign o_replaced    = r_replaced;
    assign o_victim_page = r_victim;
    assign o_fault_total = r_fault;

endmodule

`default_nettype wire

>>> sv/pfr_frame_ram.sv
// Frame table memory: resident page and usage record per frame, one read and one write port.
`default_nettype none

module pfr_frame_ram #(
    parameter int MAX_FRAMES = 16,
    parameter int PAGE_BITS  = 16,
    parameter int AW         = 4
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_rd_en,
    input  wire logic [AW-1:0]        i_rd_addr,
    output logic      [PAGE_BITS-1:0] o_rd_page,
    output pfr_pkg::t_usage           o_rd_use,
    input  wire logic                 i_wr_en,
    input  wire logic [AW-1:0]        i_wr_addr,
    input  wire logic [PAGE_BITS-1:0] i_wr_page,
    input  wire pfr_pkg::t_usage      i_wr_use
);

    localparam int RW = PAGE_BITS + $bits(pfr_pkg::t_usage);

    logic [RW-1:0]         r_mem [MAX_FRAMES];
    logic [MAX_FRAMES-1:0] r_vld;
    logic [RW-1:0]         r_rd_row;
    logic                  r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= {i_wr_page, i_wr_use};
        end
        if (i_rd_en) begin
            r_rd_row <= r_mem[i_rd_addr];
            r_rd_vld <= r_vld[i_rd_addr];
        end
    end

    // Usage of a never-written frame reads as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr_en) begin
            r_vld[i_wr_addr] <= 1'b1;
        end
    end

    assign o_rd_page = r_rd_row[RW-1 -: PAGE_BITS];
    assign o_rd_use  = r_rd_vld ? pfr_pkg::t_usage'(r_rd_row[RW-PAGE_BITS-1:0]) : '0;

endmodule

`default_nettype wire

>>> sv/pfr_scan.sv
// Scan unit: one frame per cycle, tracks the hit frame, the LRU/LFU victim and the FIFO slot.
`default_nettype none

module pfr_scan #(
    parameter int PAGE_BITS = 16,
    parameter int AW        = 4,
    parameter int CW        = 5
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic                 i_vld,
    input  wire logic [AW-1:0]        i_idx,
    input  wire logic [PAGE_BITS-1:0] i_page,
    input  wire pfr_pkg::t_usage      i_use,
    input  wire logic [PAGE_BITS-1:0] i_key,
    input  wire logic [CW-1:0]        i_used,
    input  wire logic [AW-1:0]        i_slot,
    input  wire pfr_pkg::t_policy     i_pol,
    output logic                      o_hit,
    output logic      [AW-1:0]        o_hit_idx,
    output pfr_pkg::t_usage           o_hit_use,
    output logic      [AW-1:0]        o_best_idx,
    output logic      [PAGE_BITS-1:0] o_best_page,
    output pfr_pkg::t_usage           o_best_use,
    output logic      [PAGE_BITS-1:0] o_fifo_page,
    output pfr_pkg::t_usage           o_fifo_use
);

    logic                 r_found;
    logic                 r_have;
    logic [AW-1:0]        r_hit_idx;
    pfr_pkg::t_usage      r_hit_use;
    logic [AW-1:0]        r_best_idx;
    logic [PAGE_BITS-1:0] r_best_page;
    pfr_pkg::t_usage      r_best_use;
    logic [PAGE_BITS-1:0] r_fifo_page;
    pfr_pkg::t_usage      r_fifo_use;

    logic is_hit;
    logic is_better;

    assign is_hit = i_vld && !r_found && (CW'(i_idx) < i_used) && (i_page == i_key);

    // Strict compare keeps the first frame on ties.
    always_comb begin
        if (!r_have) begin
            is_better = 1'b1;
        end else if (i_pol == pfr_pkg::POL_LFU) begin
            is_better = (i_use.count < r_best_use.count) ||
                        ((i_use.count == r_best_use.count) &&
                         (i_use.stamp < r_best_use.stamp));
        end else begin
            is_better = i_use.stamp < r_best_use.stamp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_start) begin
            r_found <= 1'b0;
            r_have  <= 1'b0;
        end else if (i_vld) begin
            r_have <= 1'b1;
            if (is_hit) begin
                r_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (is_hit) begin
            r_hit_idx <= i_idx;
            r_hit_use <= i_use;
        end
        if (i_vld && is_better) begin
            r_best_idx  <= i_idx;
            r_best_page <= i_page;
            r_best_use  <= i_use;
        end
        if (i_vld && (i_idx == i_slot)) begin
            r_fifo_page <= i_page;
            r_fifo_use  <= i_use;
        end
    end

    assign o_hit       = r_found;
    assign o_hit_idx   = r_hit_idx;
    assign o_hit_use   = r_hit_use;
    assign o_best_idx  = r_best_idx;
    assign o_best_page = r_best_page;
    assign o_best_use  = r_best_use;
    assign o_fifo_page = r_fifo_page;
    assign o_fifo_use  = r_fifo_use;

endmodule

`default_nettype wire

>>> sv/pfr_checker.sv
// Port-level checker for the page frame replacement core, with its bind.
`default_nettype none

module pfr_checker #(
    parameter int PAGE_BITS = 16
) (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        o_out_valid,
    input wire logic                        i_out_stall,
    input wire logic                        o_hit,
    input wire logic                        o_replaced,
    input wire logic [PAGE_BITS-1:0]        o_victim_page,
    input wire logic [pfr_pkg::TOTAL_W-1:0] o_fault_total
);

    // A result is never a hit and an eviction at once.
    a_hit_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_hit && o_replaced))
        else $error("hit and replaced both set");

    // Victim page reads zero when nothing was evicted.
    a_victim_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_replaced) |-> (o_victim_page == '0))
        else $error("victim page nonzero without eviction");

    // No result is pending right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // A stalled result stays offered with the same miss total.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_fault_total)))
        else $error("stalled result changed");

endmodule

bind page_frame_replacement_core pfr_checker #(
    .PAGE_BITS (PAGE_BITS)
) u_pfr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_hit         (o_hit),
    .o_replaced    (o_replaced),
    .o_victim_page (o_victim_page),
    .o_fault_total (o_fault_total)
);

`default_nettype wire
